/* rtl/ipnf_pkg.sv */
// Shared types and constants for the isolated pixel noise filter.
// Used by the front end, the command queue, the back end and the top level.
package ipnf_pkg;

  localparam int DIM_W       = 11;  // width/height register width
  localparam int LIMIT_W     = 8;   // grey difference limit width
  localparam int PIX_W       = 24;  // packed pixel, red in the low byte
  localparam int POS_W       = 12;  // column field, covers up to 4096 columns
  localparam int BANK_W      = 4;   // row bank index, covers up to 16 banks
  localparam int ROOM_W      = 2;   // rows available above/below, up to 3
  localparam int QUEUE_DEPTH = 2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_LIMIT  = 2'd2;

  typedef logic [PIX_W-1:0] pixel_t;

  // One result to produce: centre position and how the window rows clamp.
  typedef struct packed {
    logic [POS_W-1:0]  col;
    logic [BANK_W-1:0] bank;
    logic [ROOM_W-1:0] up;
    logic [ROOM_W-1:0] down;
    logic              last;
  } cmd_t;

  // Pixel write into the row banks.
  typedef struct packed {
    logic              en;
    logic [BANK_W-1:0] bank;
    logic [POS_W-1:0]  col;
    pixel_t            px;
  } wr_t;

endpackage

/* rtl/isolated_pixel_noise_filter.sv */
// Top level of the isolated pixel noise filter: configuration registers,
// front end, command queue and back end. Depends on ipnf_pkg.
//
//   port group            direction  handshake          payload
//   input pixels          in         in_valid/in_stall  opcode, red_in, green_in, blue_in
//   filtered pixels       out        out_valid/out_stall red_out, green_out, blue_out,
//                                                         was_replaced, last_of_image
//   configuration (APB)   in/out     psel/penable/pready paddr, pwdata, prdata
//
// One item a cycle while neither in_stall nor out_stall is raised. The first result of each row waits in
// the back end, which fills its column window through the shared row-bank read address.
// The first pixel of an image waits until the command queue is empty.
// A result passes the command queue, then the bank read, window, grey/sum and output registers.
// Reset is synchronous; the row banks are not cleared.
// The front end keeps accepting while the output stalls, until the queue is full.
module isolated_pixel_noise_filter #(
  parameter int WINDOW_SPAN = 3,
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic        was_replaced,
  output logic        last_of_image
);
  import ipnf_pkg::*;

  logic [DIM_W-1:0]   image_width, image_height;
  logic [LIMIT_W-1:0] grey_difference_limit;
  logic               cfg_write, restart;
  logic [$clog2(MAX_WIDTH+1)-1:0] used_w;

  logic q_full, q_empty, q_push, q_pop;
  cmd_t q_in, q_out;
  wr_t  wr;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign restart   = cfg_write && (paddr[3:2] == REG_WIDTH || paddr[3:2] == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width           <= DIM_W'(1024);
      image_height          <= DIM_W'(1024);
      grey_difference_limit <= LIMIT_W'(5);
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_WIDTH:  image_width           <= pwdata[DIM_W-1:0];
        REG_HEIGHT: image_height          <= pwdata[DIM_W-1:0];
        REG_LIMIT:  grey_difference_limit <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = 32'(image_width);
      REG_HEIGHT: prdata = 32'(image_height);
      REG_LIMIT:  prdata = 32'(grey_difference_limit);
      default:    prdata = '0;
    endcase
  end

  ipnf_front #(
    .WINDOW_SPAN(WINDOW_SPAN),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .red_in      (red_in),
    .green_in    (green_in),
    .blue_in     (blue_in),
    .restart     (restart),
    .image_width (image_width),
    .image_height(image_height),
    .used_w      (used_w),
    .q_full      (q_full),
    .q_empty     (q_empty),
    .q_push      (q_push),
    .q_cmd       (q_in),
    .wr          (wr)
  );

  ipnf_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_in),
    .pop  (q_pop),
    .dout (q_out),
    .full (q_full),
    .empty(q_empty)
  );

  ipnf_back #(
    .WINDOW_SPAN(WINDOW_SPAN),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (!q_empty),
    .q_cmd        (q_out),
    .q_pop        (q_pop),
    .wr           (wr),
    .used_w       (used_w),
    .limit        (grey_difference_limit),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .was_replaced (was_replaced),
    .last_of_image(last_of_image)
  );

endmodule

/* rtl/ipnf_front.sv */
// Front end: accepts pixels and drains, tracks input and output positions,
// writes pixels to the row banks and issues one command per result.
// Depends on ipnf_pkg.
module ipnf_front #(
  parameter int WINDOW_SPAN = 3,
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             opcode,
  input  logic [7:0]                       red_in,
  input  logic [7:0]                       green_in,
  input  logic [7:0]                       blue_in,
  input  logic                             restart,
  input  logic [ipnf_pkg::DIM_W-1:0]       image_width,
  input  logic [ipnf_pkg::DIM_W-1:0]       image_height,
  output logic [$clog2(MAX_WIDTH+1)-1:0]   used_w,
  input  logic                             q_full,
  input  logic                             q_empty,
  output logic                             q_push,
  output ipnf_pkg::cmd_t                   q_cmd,
  output ipnf_pkg::wr_t                    wr
);
  import ipnf_pkg::*;

  localparam int HALF = (WINDOW_SPAN - 1) / 2;
  localparam int NB   = 3 * HALF + QUEUE_DEPTH + 1;
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int PW   = $clog2(HALF * MAX_WIDTH + HALF + 2);

  logic [HW-1:0]     in_row, in_row_next;
  logic [CW-1:0]     in_col, in_col_next;
  logic [BANK_W-1:0] in_bank, in_bank_next;
  logic [RW-1:0]     out_row, out_row_next;
  logic [CW-1:0]     out_col, out_col_next;
  logic [BANK_W-1:0] out_bank, out_bank_next;
  logic [PW-1:0]     pend, pend_next;

  logic [HW-1:0] used_h;
  logic [HW-1:0] below;
  logic [PW-1:0] lag;
  logic          done, at_start, accept, do_write, do_emit;
  logic          in_wrap, out_wrap, out_last;

  function automatic logic [BANK_W-1:0] bank_inc(logic [BANK_W-1:0] b);
    return (b == BANK_W'(NB - 1)) ? '0 : b + BANK_W'(1);
  endfunction

  always_comb begin
    if (image_width == '0) begin
      used_w = WW'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      used_w = WW'(MAX_WIDTH);
    end else begin
      used_w = WW'(image_width);
    end
    if (image_height == '0) begin
      used_h = HW'(1);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      used_h = HW'(MAX_HEIGHT);
    end else begin
      used_h = HW'(image_height);
    end
    lag      = PW'(HALF) * PW'(used_w) + PW'(HALF);
    done     = in_row >= used_h;
    at_start = (in_row == '0) && (in_col == '0) && (pend == '0);
    // hold the first pixel of an image until earlier reads are all issued
    in_stall = q_full || (at_start && !q_empty);
    accept   = in_valid && !in_stall;
    do_write = accept && (opcode == OP_PIXEL) && !done;
    do_emit  = accept && ((opcode == OP_PIXEL) ? (!done && pend >= lag) : done);
    in_wrap  = (WW'(in_col) + WW'(1)) == used_w;
    out_wrap = (WW'(out_col) + WW'(1)) == used_w;
    out_last = out_wrap && (out_row == RW'(used_h - HW'(1)));
    below    = used_h - HW'(out_row) - HW'(1);
  end

  always_comb begin
    in_row_next   = in_row;
    in_col_next   = in_col;
    in_bank_next  = in_bank;
    out_row_next  = out_row;
    out_col_next  = out_col;
    out_bank_next = out_bank;
    pend_next     = pend;
    if (do_write) begin
      if (in_wrap) begin
        in_col_next  = '0;
        in_row_next  = in_row + HW'(1);
        in_bank_next = bank_inc(in_bank);
      end else begin
        in_col_next = in_col + CW'(1);
      end
      if (!do_emit) begin
        pend_next = pend + PW'(1);
      end
    end
    if (do_emit) begin
      if (out_last) begin
        in_row_next   = '0;
        in_col_next   = '0;
        out_row_next  = '0;
        out_col_next  = '0;
        pend_next     = '0;
        out_bank_next = in_bank_next;
      end else if (out_wrap) begin
        out_col_next  = '0;
        out_row_next  = out_row + RW'(1);
        out_bank_next = bank_inc(out_bank);
      end else begin
        out_col_next = out_col + CW'(1);
      end
    end
    if (restart) begin
      in_row_next   = '0;
      in_col_next   = '0;
      out_row_next  = '0;
      out_col_next  = '0;
      pend_next     = '0;
      out_bank_next = in_bank;
      in_bank_next  = in_bank;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row   <= '0;
      in_col   <= '0;
      in_bank  <= '0;
      out_row  <= '0;
      out_col  <= '0;
      out_bank <= '0;
      pend     <= '0;
    end else begin
      in_row   <= in_row_next;
      in_col   <= in_col_next;
      in_bank  <= in_bank_next;
      out_row  <= out_row_next;
      out_col  <= out_col_next;
      out_bank <= out_bank_next;
      pend     <= pend_next;
    end
  end

  always_comb begin
    q_push        = do_emit;
    q_cmd.col     = POS_W'(out_col);
    q_cmd.bank    = out_bank;
    q_cmd.up      = (32'(out_row) >= 32'(HALF)) ? ROOM_W'(HALF) : ROOM_W'(out_row);
    q_cmd.down    = (32'(below) >= 32'(HALF)) ? ROOM_W'(HALF) : ROOM_W'(below);
    q_cmd.last    = out_last;
    wr.en         = do_write;
    wr.bank       = in_bank;
    wr.col        = POS_W'(in_col);
    wr.px         = {blue_in, green_in, red_in};
  end

endmodule

/* rtl/ipnf_queue.sv */
// Short command queue between the front end and the back end.
// Depends on ipnf_pkg.
module ipnf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ipnf_pkg::cmd_t din,
  input  logic           pop,
  output ipnf_pkg::cmd_t dout,
  output logic           full,
  output logic           empty
);
  import ipnf_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  cmd_t                  slots [QUEUE_DEPTH];
  logic [AW-1:0]         wptr, rptr;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] count;

  assign full  = count == ($bits(count))'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign dout  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (pop) begin
        rptr <= (rptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/ipnf_back.sv */
// Back end: row banks, column window, grey and mean arithmetic, output register.
// Reads one column of every bank per cycle while the output is not stalled; depends on ipnf_pkg.
module ipnf_back #(
  parameter int WINDOW_SPAN = 3,
  parameter int MAX_WIDTH   = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  ipnf_pkg::cmd_t                 q_cmd,
  output logic                           q_pop,
  input  ipnf_pkg::wr_t                  wr,
  input  logic [$clog2(MAX_WIDTH+1)-1:0] used_w,
  input  logic [ipnf_pkg::LIMIT_W-1:0]   limit,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     red_out,
  output logic [7:0]                     green_out,
  output logic [7:0]                     blue_out,
  output logic                           was_replaced,
  output logic                           last_of_image
);
  import ipnf_pkg::*;

  localparam int HALF  = (WINDOW_SPAN - 1) / 2;
  localparam int SIDE  = 2 * HALF + 1;
  localparam int NB    = 3 * HALF + QUEUE_DEPTH + 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int PFW   = $clog2(HALF + 1);
  localparam int NN    = SIDE * SIDE - 1;
  localparam int SW    = $clog2(255 * NN + 1);
  localparam int K     = 24;
  localparam int RECIP = (2 ** K + NN - 1) / NN;
  localparam int RCW   = $clog2(RECIP + 1);
  localparam int PRW   = SW + RCW;

  function automatic logic [7:0] grey_of(pixel_t p);
    logic [14:0] x;
    logic [27:0] m;
    x = 15'd30 * 15'(p[7:0]) + 15'd59 * 15'(p[15:8]) + 15'd11 * 15'(p[23:16])
      + 15'd50;
    // divide by 100 through a reciprocal, exact for this range
    m = 28'(x) * 28'd5243;
    return m[26:19];
  endfunction

  logic          en;
  logic [PFW-1:0] pf;
  logic          issue, load1, emit1;
  logic [WW+1:0] want;
  logic [CW-1:0] rd_addr;

  pixel_t        rd [NB];
  logic          v2, load2, emit2;
  cmd_t          cmd2;
  pixel_t        tap [SIDE];

  pixel_t        colbuf [SIDE][SIDE];
  logic          v3, last3;

  logic [7:0]    grey_r [SIDE][SIDE];
  logic [SW-1:0] sum_r, sum_g, sum_b;
  pixel_t        centre;
  logic          v4, last4;

  logic          replaced;
  logic [PRW-1:0] prod_r, prod_g, prod_b;

  assign en = !(out_valid && out_stall);

  // Issue: at the start of a row, fill the window over HALF+1 reads.
  always_comb begin
    issue = en && q_valid;
    if (q_cmd.col == '0) begin
      want  = (WW + 2)'(pf);
      load1 = pf == '0;
      emit1 = pf == PFW'(HALF);
    end else begin
      want  = (WW + 2)'(q_cmd.col[CW-1:0]) + (WW + 2)'(HALF);
      load1 = 1'b0;
      emit1 = 1'b1;
    end
    if (want > (WW + 2)'(used_w) - (WW + 2)'(1)) begin
      want = (WW + 2)'(used_w) - (WW + 2)'(1);
    end
    rd_addr = want[CW-1:0];
    q_pop   = issue && emit1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pf <= '0;
    end else if (issue) begin
      pf <= emit1 ? '0 : pf + PFW'(1);
    end
  end

  for (genvar b = 0; b < NB; b++) begin : g_bank
    pixel_t mem [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (wr.en && wr.bank == BANK_W'(b)) begin
        mem[wr.col[CW-1:0]] <= wr.px;
      end
      if (en) begin
        rd[b] <= mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      load2 <= load1;
      emit2 <= emit1;
      cmd2  <= q_cmd;
    end
  end

  // Pick each window row from its bank, clamping rows at the image edges.
  always_comb begin
    int eff;
    int t;
    for (int i = 0; i < SIDE; i++) begin
      eff = i - HALF;
      if (eff < -int'(cmd2.up)) eff = -int'(cmd2.up);
      if (eff > int'(cmd2.down)) eff = int'(cmd2.down);
      t = int'(cmd2.bank) + eff;
      if (t < 0) t = t + NB;
      if (t >= NB) t = t - NB;
      tap[i] = rd[0];
      for (int b = 0; b < NB; b++) begin
        if (t == b) tap[i] = rd[b];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && v2) begin
      for (int i = 0; i < SIDE; i++) begin
        if (load2) begin
          for (int j = 0; j < SIDE; j++) begin
            colbuf[j][i] <= tap[i];
          end
        end else begin
          for (int j = 0; j < SIDE - 1; j++) begin
            colbuf[j][i] <= colbuf[j+1][i];
          end
          colbuf[SIDE-1][i] <= tap[i];
        end
      end
    end
    if (en) begin
      last3 <= cmd2.last;
    end
  end

  always_ff @(posedge clk) begin
    logic [SW-1:0] sr, sg, sb;
    sr = '0;
    sg = '0;
    sb = '0;
    if (en) begin
      for (int i = 0; i < SIDE; i++) begin
        for (int j = 0; j < SIDE; j++) begin
          grey_r[i][j] <= grey_of(colbuf[j][i]);
          if (!(i == HALF && j == HALF)) begin
            sr = sr + SW'(colbuf[j][i][7:0]);
            sg = sg + SW'(colbuf[j][i][15:8]);
            sb = sb + SW'(colbuf[j][i][23:16]);
          end
        end
      end
      sum_r  <= sr;
      sum_g  <= sg;
      sum_b  <= sb;
      centre <= colbuf[HALF][HALF];
      last4  <= last3;
    end
  end

  always_comb begin
    logic [7:0] d;
    replaced = 1'b1;
    for (int i = 0; i < SIDE; i++) begin
      for (int j = 0; j < SIDE; j++) begin
        d = (grey_r[HALF][HALF] > grey_r[i][j]) ? grey_r[HALF][HALF] - grey_r[i][j]
                                                : grey_r[i][j] - grey_r[HALF][HALF];
        if (!(i == HALF && j == HALF) && d <= limit) replaced = 1'b0;
      end
    end
    prod_r = PRW'(sum_r) * PRW'(RECIP);
    prod_g = PRW'(sum_g) * PRW'(RECIP);
    prod_b = PRW'(sum_b) * PRW'(RECIP);
  end

  always_ff @(posedge clk) begin
    if (en && v4) begin
      red_out       <= replaced ? prod_r[K+7:K] : centre[7:0];
      green_out     <= replaced ? prod_g[K+7:K] : centre[15:8];
      blue_out      <= replaced ? prod_b[K+7:K] : centre[23:16];
      was_replaced  <= replaced;
      last_of_image <= last4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v2        <= issue;
      v3        <= v2 && emit2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

endmodule
